FILE: sv/hit_time_bunch_clusterer_assert.svh
// Assertion macros for the hit time bunch clusterer checker.
`ifndef HIT_TIME_BUNCH_CLUSTERER_ASSERT_SVH
`define HIT_TIME_BUNCH_CLUSTERER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HTB_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("htb assertion failed");

// Consequent checked in the cycle after the antecedent.
`define HTB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("htb assertion failed");

`endif

FILE: sv/htb_pkg.sv
// Shared types and constants of the hit time bunch clusterer.
package htb_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned SpanW   = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ChanW   = 6;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned NewChannels = 4;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [ChanW:0]    NewChanLimit = (ChanW + 1)'(NewChannels);
  localparam logic [CfgW-1:0]   CutoffReset  = 32'd40000;
  localparam logic [CfgW-1:0]   RangeReset   = 32'd500000;
  localparam logic [CountW-1:0] CountMax     = '1;

  typedef enum logic [1:0] {
    OP_HIT,
    OP_FLUSH,
    OP_BAD
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CUTOFF = 2'd0,
    REG_RANGE  = 2'd1,
    REG_WEIGHT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    op_e              op;
    logic             group;
    logic [TimeW-1:0] hit_time;
  } entry_t;

  typedef struct packed {
    logic [CfgW-1:0] bunch_cutoff;
    logic [CfgW-1:0] bunch_range;
    logic            weight_by_size;
  } cfg_t;

  typedef struct packed {
    logic              status;
    logic              group;
    logic [SpanW-1:0]  span;
    logic [CountW-1:0] size;
    logic [CountW-1:0] weight;
    logic              last;
  } result_t;

endpackage

FILE: sv/htb_queue.sv
// Small FIFO that holds classified items between the front and back parts.
module htb_queue #(
  parameter int unsigned Depth = htb_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  htb_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output htb_pkg::entry_t data_o
);
  import htb_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

FILE: sv/htb_front.sv
// Front part: accepts input items, classifies them and queues them for the back part.
module htb_front #(
  parameter int unsigned Depth = htb_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic [htb_pkg::TimeW-1:0] hit_time_i,
  input  logic                      channel_side_i,
  input  logic [htb_pkg::ChanW-1:0] channel_number_i,
  output htb_pkg::entry_t           head_o,
  output logic                      head_valid_o,
  input  logic                      pop_i
);
  import htb_pkg::*;

  entry_t entry;
  logic   bad_chan;
  logic   full;
  logic   push;

  always_comb begin
    bad_chan       = channel_side_i && ({1'b0, channel_number_i} >= NewChanLimit);
    entry.group    = channel_side_i;
    entry.hit_time = hit_time_i;
    if (kind_i) begin
      entry.op = OP_FLUSH;
    end else if (bad_chan) begin
      entry.op = OP_BAD;
    end else begin
      entry.op = OP_HIT;
    end
  end

  assign in_ready_o = !full;
  assign push       = in_valid_i && !full;

  htb_queue #(
    .Depth(Depth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (entry),
    .full_o (full),
    .pop_i  (pop_i),
    .valid_o(head_valid_o),
    .data_o (head_o)
  );

endmodule

FILE: sv/htb_back.sv
// Back part: keeps the open bunch of each group and produces the result items.
module htb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  htb_pkg::cfg_t    cfg_i,
  input  htb_pkg::entry_t  head_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output htb_pkg::result_t result_o
);
  import htb_pkg::*;

  logic [TimeW-1:0]  first_q [2];
  logic [TimeW-1:0]  first_d [2];
  logic [TimeW-1:0]  last_q  [2];
  logic [TimeW-1:0]  last_d  [2];
  logic [CountW-1:0] count_q [2];
  logic [CountW-1:0] count_d [2];
  logic [1:0]        open_q, open_d;
  logic              out_valid_q, out_valid_d;
  result_t           result_q, result_d;

  logic              grp;
  logic [TimeW-1:0]  t;
  logic [TimeW-1:0]  diff_first;
  logic [TimeW-1:0]  diff_last;
  logic              joins;
  logic              out_free;
  logic              go;
  logic              emit;

  function automatic result_t bunch_rec(input logic g, input logic [TimeW-1:0] first,
                                        input logic [TimeW-1:0] last,
                                        input logic [CountW-1:0] count,
                                        input logic wbs, input logic fin);
    result_t r;
    logic [TimeW-1:0] span;
    span     = last - first;
    r.status = 1'b0;
    r.group  = g;
    r.span   = span[SpanW-1:0];
    r.size   = count;
    r.weight = wbs ? count : CountW'(1);
    r.last   = fin;
    return r;
  endfunction

  always_comb begin
    grp        = head_i.group;
    t          = head_i.hit_time;
    diff_first = t - first_q[grp];
    diff_last  = t - last_q[grp];
    joins      = (t >= last_q[grp])
              && (diff_first < TimeW'(cfg_i.bunch_range))
              && (diff_last < TimeW'(cfg_i.bunch_cutoff));
    out_free   = !out_valid_q || out_ready_i;
    go         = head_valid_i && out_free;
  end

  always_comb begin
    first_d  = first_q;
    last_d   = last_q;
    count_d  = count_q;
    open_d   = open_q;
    result_d = result_q;
    emit     = 1'b0;
    pop_o    = 1'b0;
    if (go) begin
      unique case (head_i.op)
        OP_BAD: begin
          pop_o           = 1'b1;
          emit            = 1'b1;
          result_d.status = 1'b1;
          result_d.group  = 1'b1;
          result_d.span   = '0;
          result_d.size   = '0;
          result_d.weight = '0;
          result_d.last   = 1'b1;
        end
        OP_HIT: begin
          pop_o = 1'b1;
          if (open_q[grp] && joins) begin
            last_d[grp] = t;
            if (count_q[grp] != CountMax) begin
              count_d[grp] = count_q[grp] + 1'b1;
            end
          end else begin
            if (open_q[grp]) begin
              emit     = 1'b1;
              result_d = bunch_rec(grp, first_q[grp], last_q[grp], count_q[grp],
                                   cfg_i.weight_by_size, 1'b1);
            end
            first_d[grp] = t;
            last_d[grp]  = t;
            count_d[grp] = CountW'(1);
            open_d[grp]  = 1'b1;
          end
        end
        OP_FLUSH: begin
          if (open_q[0]) begin
            emit      = 1'b1;
            result_d  = bunch_rec(1'b0, first_q[0], last_q[0], count_q[0],
                                  cfg_i.weight_by_size, !open_q[1]);
            open_d[0] = 1'b0;
            pop_o     = !open_q[1];
          end else begin
            pop_o = 1'b1;
            if (open_q[1]) begin
              emit      = 1'b1;
              result_d  = bunch_rec(1'b1, first_q[1], last_q[1], count_q[1],
                                    cfg_i.weight_by_size, 1'b1);
              open_d[1] = 1'b0;
            end
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    last_q   <= last_d;
    count_q  <= count_d;
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

FILE: sv/hit_time_bunch_clusterer.sv
// Top level of the hit time bunch clusterer: configuration registers, front and back parts.
// A result item is registered at the output once its item has passed through the queue.
// Throughput: one item per cycle while the output register is free; a flush that closes
// both groups' bunches gives one result per group, group 0 first, while the front keeps
// queuing items until the queue is full. Reset clears the item queue, the open-bunch flags
// and the output valid flag, and returns the configuration registers to their defaults.
module hit_time_bunch_clusterer #(
  parameter int unsigned QueueDepth = htb_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [htb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [htb_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [htb_pkg::TimeW-1:0]   hit_time_i,
  input  logic                        channel_side_i,
  input  logic [htb_pkg::ChanW-1:0]   channel_number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic                        group_o,
  output logic [htb_pkg::SpanW-1:0]   bunch_span_o,
  output logic [htb_pkg::CountW-1:0]  bunch_size_o,
  output logic [htb_pkg::CountW-1:0]  weight_o,
  output logic                        last_of_run_o
);
  import htb_pkg::*;

  cfg_t    cfg_q, cfg_d;
  entry_t  head;
  logic    head_valid;
  logic    pop;
  result_t result;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CUTOFF: cfg_d.bunch_cutoff   = cfg_wdata_i;
        REG_RANGE:  cfg_d.bunch_range    = cfg_wdata_i;
        REG_WEIGHT: cfg_d.weight_by_size = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bunch_cutoff   <= CutoffReset;
      cfg_q.bunch_range    <= RangeReset;
      cfg_q.weight_by_size <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  htb_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .hit_time_i      (hit_time_i),
    .channel_side_i  (channel_side_i),
    .channel_number_i(channel_number_i),
    .head_o          (head),
    .head_valid_o    (head_valid),
    .pop_i           (pop)
  );

  htb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign status_o      = result.status;
  assign group_o       = result.group;
  assign bunch_span_o  = result.span;
  assign bunch_size_o  = result.size;
  assign weight_o      = result.weight;
  assign last_of_run_o = result.last;

endmodule

FILE: sv/htb_checker.sv
// Port-level checker for the hit time bunch clusterer and its bind statement.
`include "hit_time_bunch_clusterer_assert.svh"

module htb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        status_o,
  input logic                        group_o,
  input logic [htb_pkg::SpanW-1:0]   bunch_span_o,
  input logic [htb_pkg::CountW-1:0]  bunch_size_o,
  input logic [htb_pkg::CountW-1:0]  weight_o,
  input logic                        last_of_run_o
);
  import htb_pkg::*;

  result_t shown;
  logic    bad_fields_ok;
  logic    bunch_fields_ok;
  logic    first_of_two;
  logic    second_of_two;

  assign shown = {status_o, group_o, bunch_span_o, bunch_size_o, weight_o, last_of_run_o};
  assign bad_fields_ok = group_o && last_of_run_o && (bunch_span_o == '0)
                         && (bunch_size_o == '0) && (weight_o == '0);
  assign bunch_fields_ok = (bunch_size_o != '0) && (weight_o != '0)
                           && (weight_o <= bunch_size_o);
  assign first_of_two = out_valid_o && out_ready_i && !status_o && !group_o && !last_of_run_o;
  assign second_of_two = out_valid_o && !status_o && group_o && last_of_run_o;

  `HTB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(shown))

  `HTB_ASSERT_NOW(a_bad_record, out_valid_o && status_o, bad_fields_ok)

  `HTB_ASSERT_NOW(a_bunch_nonempty, out_valid_o && !status_o, bunch_fields_ok)

  `HTB_ASSERT_NEXT(a_group0_then_group1, first_of_two, second_of_two)

endmodule

bind hit_time_bunch_clusterer htb_checker u_htb_checker (.*);

FILE: sim/tb_hit_time_bunch_clusterer.sv
// Testbench for hit_time_bunch_clusterer: random hit streams checked against a bunch predictor.
module tb_hit_time_bunch_clusterer;
  timeunit 1ns;
  timeprecision 1ps;
  import htb_pkg::*;

  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_FLUSH   = 1'b1;
  localparam logic STATUS_BUNCH = 1'b0;
  localparam logic STATUS_DROP  = 1'b1;
  localparam logic GROUP_NEW    = 1'b1;

  localparam int RAND_ITEMS   = 180;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_PRINTS   = 30;

  typedef struct packed {
    logic             kind;
    logic [TimeW-1:0] stamp;
    logic             side;
    logic [ChanW-1:0] chan;
  } hit_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  reg_idx_e cfg_idx = REG_CUTOFF;
  logic [CfgW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [TimeW-1:0] in_stamp = '0;
  logic in_side = 1'b0;
  logic [ChanW-1:0] in_chan = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_status;
  logic out_group;
  logic [SpanW-1:0] out_span;
  logic [CountW-1:0] out_size;
  logic [CountW-1:0] out_weight;
  logic out_last;

  hit_time_bunch_clusterer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .kind_i          (in_kind),
    .hit_time_i      (in_stamp),
    .channel_side_i  (in_side),
    .channel_number_i(in_chan),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (out_status),
    .group_o         (out_group),
    .bunch_span_o    (out_span),
    .bunch_size_o    (out_size),
    .weight_o        (out_weight),
    .last_of_run_o   (out_last)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor copy of the configuration and of the per-group bunch state.
  logic [CfgW-1:0] cutoff_ps = CutoffReset;
  logic [CfgW-1:0] range_ps = RangeReset;
  logic weigh_size = 1'b1;
  logic [TimeW-1:0] bunch_first [2] = '{default: '0};
  logic [TimeW-1:0] bunch_last [2] = '{default: '0};
  logic [CountW-1:0] bunch_hits [2] = '{default: '0};
  logic bunch_live [2] = '{default: 1'b0};

  hit_item_t hit_q [$];
  result_t record_q [$];
  hit_item_t offered;
  logic [TimeW-1:0] cursor [2] = '{default: '0};

  int idle_pct = 13;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  int n_errors = 0;
  int n_items = 0;
  int n_flushes = 0;
  int n_bunches = 0;
  int n_drops = 0;
  int n_settings = 0;

  function automatic result_t bunch_record(int g, logic last);
    result_t r;
    r.status = STATUS_BUNCH;
    r.group  = g[0];
    r.span   = SpanW'(bunch_last[g] - bunch_first[g]);
    r.size   = bunch_hits[g];
    r.weight = weigh_size ? bunch_hits[g] : CountW'(1);
    r.last   = last;
    return r;
  endfunction

  task automatic enqueue_item(hit_item_t it);
    hit_q.insert(hit_q.size(), it);
  endtask

  task automatic enqueue_record(result_t r);
    record_q.insert(record_q.size(), r);
  endtask

  task automatic predict_bunches(hit_item_t it);
    int g;
    logic joins;
    result_t drop;
    g = int'(it.side);
    if (it.kind == KIND_FLUSH) begin
      if (bunch_live[0]) begin
        enqueue_record(bunch_record(0, !bunch_live[1]));
        bunch_live[0] = 1'b0;
      end
      if (bunch_live[1]) begin
        enqueue_record(bunch_record(1, 1'b1));
        bunch_live[1] = 1'b0;
      end
      n_flushes++;
    end else if (it.side == GROUP_NEW && it.chan >= NewChannels) begin
      drop = '0;
      drop.status = STATUS_DROP;
      drop.group = GROUP_NEW;
      drop.last = 1'b1;
      enqueue_record(drop);
    end else begin
      joins = 1'b0;
      if (bunch_live[g]) begin
        joins = it.stamp >= bunch_last[g]
            && (it.stamp - bunch_first[g]) < TimeW'(range_ps)
            && (it.stamp - bunch_last[g]) < TimeW'(cutoff_ps);
        if (!joins) enqueue_record(bunch_record(g, 1'b1));
      end
      if (joins) begin
        bunch_last[g] = it.stamp;
        if (bunch_hits[g] != CountMax) bunch_hits[g]++;
      end else begin
        bunch_first[g] = it.stamp;
        bunch_last[g] = it.stamp;
        bunch_hits[g] = CountW'(1);
        bunch_live[g] = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("ERROR %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_record();
    result_t want;
    if (record_q.size() == 0) begin
      report_mismatch("record with none expected, span", out_span, 0);
    end else begin
      want = record_q.pop_front();
      if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      if (out_group !== want.group) report_mismatch("group", out_group, want.group);
      if (out_span !== want.span) report_mismatch("bunch_span", out_span, want.span);
      if (out_size !== want.size) report_mismatch("bunch_size", out_size, want.size);
      if (out_weight !== want.weight) report_mismatch("weight", out_weight, want.weight);
      if (out_last !== want.last) report_mismatch("last_of_run", out_last, want.last);
      if (want.status == STATUS_DROP) n_drops++;
      else n_bunches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_bunches(offered);
        n_items++;
      end
      if (!in_valid || in_ready) begin
        if (hit_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          offered = hit_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= offered.kind;
          in_stamp <= offered.stamp;
          in_side <= offered.side;
          in_chan <= offered.chan;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_record();
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= idle_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR %0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic hit_item_t mk_hit(logic [TimeW-1:0] stamp, logic side, logic [ChanW-1:0] chan);
    hit_item_t it;
    it.kind = KIND_HIT;
    it.stamp = stamp;
    it.side = side;
    it.chan = chan;
    return it;
  endfunction

  // The fields other than the kind are ignored on a flush, so they carry junk.
  function automatic hit_item_t mk_flush();
    hit_item_t it;
    it = hit_item_t'({$urandom, $urandom});
    it.kind = KIND_FLUSH;
    return it;
  endfunction

  function automatic logic [TimeW-1:0] next_stamp(logic [TimeW-1:0] now);
    int unsigned pick;
    logic [TimeW-1:0] cut;
    pick = $urandom_range(99);
    cut = TimeW'(cutoff_ps);
    if (pick < 8) return now;
    if (pick < 58) return (cut == 0) ? now : now + (TimeW'($urandom) % cut);
    if (pick < 68) return now + cut - TimeW'($urandom_range(1, 0));
    if (pick < 84) return now + cut + TimeW'($urandom_range(1000, 0));
    if (pick < 93) return now + TimeW'($urandom);
    return now - TimeW'($urandom_range(1000, 1));
  endfunction

  task automatic queue_random(int count);
    logic side;
    logic [ChanW-1:0] chan;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5) begin
        enqueue_item(mk_flush());
      end else begin
        side = 1'($urandom_range(1, 0));
        if (!side) chan = ChanW'($urandom_range(63, 0));
        else if ($urandom_range(99) < 12) chan = ChanW'($urandom_range(63, NewChannels));
        else chan = ChanW'($urandom_range(NewChannels - 1, 0));
        if ($urandom_range(99) < 3) cursor[side] = TimeW'({$urandom, $urandom});
        else cursor[side] = next_stamp(cursor[side]);
        enqueue_item(mk_hit(cursor[side], side, chan));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (hit_q.size() != 0 || in_valid || record_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_CUTOFF: cutoff_ps = data;
      REG_RANGE: range_ps = data;
      default: weigh_size = data[0];
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic [CfgW-1:0] cut, logic [CfgW-1:0] rng, logic [CfgW-1:0] wgt);
    wait_drained();
    write_reg(REG_CUTOFF, cut);
    write_reg(REG_RANGE, rng);
    write_reg(REG_WEIGHT, wgt);
    n_settings++;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults: flush with nothing open, joins, gap at the cutoff, dropped channels,
    // time going backwards, a two-group flush and the largest timestamps.
    enqueue_item(mk_flush());
    enqueue_item(mk_hit(48'd0, 1'b0, 6'd0));
    enqueue_item(mk_hit(48'd39999, 1'b0, 6'd63));
    enqueue_item(mk_hit(48'd79999, 1'b0, 6'd21));
    enqueue_item(mk_hit(48'd5, 1'b1, 6'(NewChannels)));
    enqueue_item(mk_hit('1, 1'b1, 6'd63));
    enqueue_item(mk_hit(48'd100000, 1'b1, 6'(NewChannels - 1)));
    enqueue_item(mk_hit(48'd100000, 1'b1, 6'd0));
    enqueue_item(mk_hit(48'd79998, 1'b0, 6'd42));
    enqueue_item(mk_flush());
    enqueue_item(mk_flush());
    enqueue_item(mk_hit('1, 1'b1, 6'd1));
    enqueue_item(mk_hit('1, 1'b1, 6'd2));
    enqueue_item(mk_hit(48'hFFFF_FFFF_FFFE, 1'b0, 6'd0));

    // A zero cutoff written while bunches are open applies to the next hit.
    wait_drained();
    write_reg(REG_CUTOFF, '0);
    enqueue_item(mk_hit(48'hFFFF_FFFF_FFFE, 1'b0, 6'd0));
    enqueue_item(mk_flush());

    wait_drained();
    write_reg(REG_CUTOFF, CutoffReset);
    write_reg(REG_RANGE, '0);
    enqueue_item(mk_hit(48'd5, 1'b0, 6'd7));
    enqueue_item(mk_hit(48'd5, 1'b0, 6'd8));
    enqueue_item(mk_flush());

    apply_setting(CutoffReset, RangeReset, 32'd1);
    queue_random(RAND_ITEMS);

    // Receiver stalls while every hit closes a bunch, so the block backs up.
    apply_setting('0, RangeReset, 32'hFFFF_FFFE);
    hold_req = 1'b1;
    queue_random(RAND_ITEMS);

    apply_setting('1, '1, 32'h8000_0001);
    idle_pct = 0;
    queue_random(RAND_ITEMS);

    apply_setting(32'd1000, 32'd3000, $urandom);
    idle_pct = 13;
    queue_random(RAND_ITEMS);

    apply_setting(32'd500000, '0, 32'd1);
    queue_random(RAND_ITEMS);

    apply_setting($urandom_range(100000, 1), $urandom_range(1000000, 0), $urandom);
    queue_random(RAND_ITEMS);
    enqueue_item(mk_flush());

    wait_drained();
    $display("tb: %0d items over %0d register settings, %0d of them flushes", n_items,
             n_settings, n_flushes);
    $display("tb: %0d bunch records and %0d dropped hits compared", n_bunches, n_drops);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
